### rtl/pprc_pkg.sv
package pprc_pkg;

    localparam int unsigned DEF_STORE_BYTES = 4096;
    localparam int unsigned DIM_W     = 12;
    localparam int unsigned PS_W      = 4;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ROW_W     = 26;
    localparam int unsigned BADDR_W   = 32;

    localparam logic [KIND_W-1:0] KIND_WR_SRC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WR_DST = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RD_SRC = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RD_DST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COPY   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE = 3'd4;

    localparam logic [PS_W-1:0] PIX_NIBBLE = 4'd0;
    localparam logic [PS_W-1:0] PIX_BIT    = 4'd1;
    localparam logic [PS_W-1:0] PIX_DIBIT  = 4'd3;
    localparam logic [PS_W-1:0] PS_RESET   = 4'd2;

    typedef struct packed {
        logic latch;
        logic host_wr;
        logic host_rd;
        logic emit_read;
        logic setup;
        logic row_first;
        logic row_calc;
        logic pix_addr;
        logic pix_chk;
        logic set_oor;
        logic cp_rd;
        logic cp_wr;
        logic byte_next;
        logic col_next;
        logic row_next;
        logic emit_copy;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              pix_ok;
        logic              first_col;
        logic              last_col;
        logic              last_row;
        logic              last_byte;
    } stat_t;

endpackage

### rtl/packed_pixel_rect_copy.sv
// packed_pixel_rect_copy: rectangle blit between a source and a destination byte store.
// command channel: an item is taken when start is high and busy is low. kind selects
// a byte write into either store, a byte read back, or a rectangle copy using the
// four offsets and the surface sizes held in the configuration registers.
// configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. writes are to be made while busy is low; the block does not enforce it.
// results: read and copy items give one result, shown for one cycle with
// result_valid high; the receiver cannot hold it off. writes give no result.
// timing: a write gives no result and busy falls once it is decoded; a read result
// is registered after the store read. a copy visits each row, then each pixel of it,
// and each byte of a multi-byte pixel is read and written in turn; a skipped pixel
// ends its row or the copy. each step is bound by the single read port of each store
// and the row-base multiply. the next item is taken once busy falls.
// reset: configuration returns to zero sizes and pixel_size 2; store contents stay
// undefined until written.
module packed_pixel_rect_copy
    import pprc_pkg::*;
#(
    parameter int unsigned STORE_BYTES = DEF_STORE_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [KIND_W-1:0]    kind,
    input  logic [DIM_W-1:0]     address,
    input  logic [7:0]           data,
    input  logic [DIM_W-1:0]     src_off_x,
    input  logic [DIM_W-1:0]     src_off_y,
    input  logic [DIM_W-1:0]     dst_off_x,
    input  logic [DIM_W-1:0]     dst_off_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output logic                 result_valid,
    output logic [7:0]           read_data,
    output logic                 copy_done,
    output logic                 out_of_range
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    pprc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    pprc_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .address      (address),
        .data         (data),
        .src_off_x    (src_off_x),
        .src_off_y    (src_off_y),
        .dst_off_x    (dst_off_x),
        .dst_off_y    (dst_off_y),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .read_data    (read_data),
        .copy_done    (copy_done),
        .out_of_range (out_of_range)
    );

    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    a_copy_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && copy_done |-> read_data == 8'd0)
        else $error("copy result carries read data");

    a_oor_on_copy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_of_range |-> copy_done)
        else $error("out_of_range flagged on a read result");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item taken without going busy");

endmodule

### rtl/pprc_ctrl.sv
module pprc_ctrl
    import pprc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_HRSP = 4'd2;
    localparam logic [3:0] S_TEST = 4'd3;
    localparam logic [3:0] S_ROW  = 4'd4;
    localparam logic [3:0] S_PADR = 4'd5;
    localparam logic [3:0] S_PCHK = 4'd6;
    localparam logic [3:0] S_PDEC = 4'd7;
    localparam logic [3:0] S_PRD  = 4'd8;
    localparam logic [3:0] S_PWR  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (stat.kind)
                    KIND_WR_SRC, KIND_WR_DST:
                    begin
                        cmd.host_wr = 1'b1;
                        state_next  = S_IDLE;
                    end
                    KIND_RD_SRC, KIND_RD_DST:
                    begin
                        cmd.host_rd = 1'b1;
                        state_next  = S_HRSP;
                    end
                    KIND_COPY:
                    begin
                        cmd.setup  = 1'b1;
                        state_next = S_TEST;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_HRSP:
            begin
                cmd.emit_read = 1'b1;
                state_next    = S_IDLE;
            end
            S_TEST:
            begin
                if (stat.empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.row_first = 1'b1;
                    state_next    = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.row_calc = 1'b1;
                state_next   = S_PADR;
            end
            S_PADR:
            begin
                cmd.pix_addr = 1'b1;
                state_next   = S_PCHK;
            end
            S_PCHK:
            begin
                cmd.pix_chk = 1'b1;
                state_next  = S_PDEC;
            end
            S_PDEC:
            begin
                if (stat.pix_ok)
                begin
                    state_next = S_PRD;
                end
                else
                begin
                    // skipped pixel ends the row, or the whole copy on the first column or the last row
                    cmd.set_oor = 1'b1;
                    if (stat.first_col || stat.last_row)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.row_next = 1'b1;
                        state_next   = S_ROW;
                    end
                end
            end
            S_PRD:
            begin
                cmd.cp_rd  = 1'b1;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                cmd.cp_wr = 1'b1;
                if (!stat.last_byte)
                begin
                    cmd.byte_next = 1'b1;
                    state_next    = S_PRD;
                end
                else if (!stat.last_col)
                begin
                    cmd.col_next = 1'b1;
                    state_next   = S_PADR;
                end
                else if (stat.last_row)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                    state_next   = S_ROW;
                end
            end
            S_DONE:
            begin
                cmd.emit_copy = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/pprc_dp.sv
module pprc_dp
    import pprc_pkg::*;
#(
    parameter int unsigned STORE_BYTES = DEF_STORE_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic [KIND_W-1:0]    kind,
    input  logic [DIM_W-1:0]     address,
    input  logic [7:0]           data,
    input  logic [DIM_W-1:0]     src_off_x,
    input  logic [DIM_W-1:0]     src_off_y,
    input  logic [DIM_W-1:0]     dst_off_x,
    input  logic [DIM_W-1:0]     dst_off_y,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output logic                 result_valid,
    output logic [7:0]           read_data,
    output logic                 copy_done,
    output logic                 out_of_range
);

    localparam int unsigned AW = $clog2(STORE_BYTES);
    localparam logic [BADDR_W-1:0] STORE_LIM = BADDR_W'(STORE_BYTES);

    logic [7:0] src_mem [STORE_BYTES];
    logic [7:0] dst_mem [STORE_BYTES];

    logic [DIM_W-1:0]  src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [PS_W-1:0]   ps_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [DIM_W-1:0]  addr_reg;
    logic [7:0]        data_reg;
    logic [DIM_W-1:0]  sx_reg, sy_reg, dx_reg, dy_reg;
    logic [DIM_W:0]    w_reg, h_reg;
    logic [DIM_W-1:0]  i_reg, j_reg;
    logic [PS_W-1:0]   q_reg;
    logic [ROW_W-1:0]  srow_reg, drow_reg, sp_reg, dp_reg;
    logic [BADDR_W-1:0] sb_reg, db_reg;
    logic              ok_reg, oor_reg;
    logic [7:0]        srd_reg, drd_reg;
    logic              valid_reg, done_reg, oor_out_reg;
    logic [7:0]        rdata_reg;

    logic              sub;
    logic [DIM_W:0]    ws, wd, hs, hd;
    logic [DIM_W:0]    sy_i, dy_i;
    logic [24:0]       sprod, dprod;
    logic [BADDR_W-1:0] sb_c, db_c, se_c, de_c, host_idx;
    logic              ok_c, haddr_ok;
    logic [BADDR_W-1:0] src_addr, dst_addr, sq_addr, dq_addr;
    logic [7:0]        merged, dst_wdata;
    logic              src_we, dst_we, src_re, dst_re;
    logic [3:0]        v4;
    logic [1:0]        v2;
    logic [2:0]        dsh;

    assign sub = (ps_reg == PIX_NIBBLE) || (ps_reg == PIX_BIT) || (ps_reg == PIX_DIBIT);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= '0;
            src_h_reg <= '0;
            dst_w_reg <= '0;
            dst_h_reg <= '0;
            ps_reg    <= PS_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_w_reg <= cfg_data;
                REG_SRC_HEIGHT: src_h_reg <= cfg_data;
                REG_DST_WIDTH:  dst_w_reg <= cfg_data;
                REG_DST_HEIGHT: dst_h_reg <= cfg_data;
                REG_PIXEL_SIZE: ps_reg    <= cfg_data[PS_W-1:0];
                default:        ;
            endcase
        end
    end

    // rectangle size, signed so that a negative extent reads as empty
    always_comb
    begin
        ws = {1'b0, src_w_reg} - {1'b0, sx_reg};
        wd = {1'b0, dst_w_reg} - {1'b0, dx_reg};
        hs = {1'b0, src_h_reg} - {1'b0, sy_reg};
        hd = {1'b0, dst_h_reg} - {1'b0, dy_reg};
        sy_i  = {1'b0, sy_reg} + {1'b0, i_reg};
        dy_i  = {1'b0, dy_reg} + {1'b0, i_reg};
        sprod = sy_i * src_w_reg;
        dprod = dy_i * dst_w_reg;
    end

    // byte address of the pixel and range check
    always_comb
    begin
        case (ps_reg)
            PIX_NIBBLE:
            begin
                sb_c = BADDR_W'(sp_reg >> 1);
                db_c = BADDR_W'(dp_reg >> 1);
            end
            PIX_BIT:
            begin
                sb_c = BADDR_W'(sp_reg >> 3);
                db_c = BADDR_W'(dp_reg >> 3);
            end
            PIX_DIBIT:
            begin
                sb_c = BADDR_W'(sp_reg >> 2);
                db_c = BADDR_W'(dp_reg >> 2);
            end
            default:
            begin
                sb_c = BADDR_W'({4'b0, sp_reg} * ps_reg);
                db_c = BADDR_W'({4'b0, dp_reg} * ps_reg);
            end
        endcase
        if (sub)
        begin
            se_c = sb_c;
            de_c = db_c;
        end
        else
        begin
            se_c = sb_c + BADDR_W'(ps_reg) - BADDR_W'(1);
            de_c = db_c + BADDR_W'(ps_reg) - BADDR_W'(1);
        end
        ok_c = (se_c < STORE_LIM) && (de_c < STORE_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oor_reg     <= 1'b0;
            valid_reg   <= 1'b0;
            done_reg    <= 1'b0;
            oor_out_reg <= 1'b0;
            rdata_reg   <= '0;
        end
        else
        begin
            valid_reg <= cmd.emit_read || cmd.emit_copy;
            if (cmd.setup)
            begin
                oor_reg <= 1'b0;
            end
            else if (cmd.set_oor)
            begin
                oor_reg <= 1'b1;
            end
            if (cmd.emit_read)
            begin
                done_reg    <= 1'b0;
                oor_out_reg <= 1'b0;
                if (!haddr_ok)
                begin
                    rdata_reg <= '0;
                end
                else if (kind_reg == KIND_RD_SRC)
                begin
                    rdata_reg <= srd_reg;
                end
                else
                begin
                    rdata_reg <= drd_reg;
                end
            end
            else if (cmd.emit_copy)
            begin
                done_reg    <= 1'b1;
                oor_out_reg <= oor_reg;
                rdata_reg   <= '0;
            end
        end
    end

    // item fields, counters and addresses
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind;
            addr_reg <= address;
            data_reg <= data;
            sx_reg   <= src_off_x;
            sy_reg   <= src_off_y;
            dx_reg   <= dst_off_x;
            dy_reg   <= dst_off_y;
        end
        if (cmd.setup)
        begin
            w_reg <= ($signed(ws) < $signed(wd)) ? ws : wd;
            h_reg <= ($signed(hs) < $signed(hd)) ? hs : hd;
        end
        if (cmd.row_first)
        begin
            i_reg <= '0;
        end
        else if (cmd.row_next)
        begin
            i_reg <= i_reg + DIM_W'(1);
        end
        if (cmd.row_calc)
        begin
            srow_reg <= {1'b0, sprod} + ROW_W'(sx_reg);
            drow_reg <= {1'b0, dprod} + ROW_W'(dx_reg);
            j_reg    <= '0;
        end
        else if (cmd.col_next)
        begin
            j_reg <= j_reg + DIM_W'(1);
        end
        if (cmd.pix_addr)
        begin
            sp_reg <= srow_reg + ROW_W'(j_reg);
            dp_reg <= drow_reg + ROW_W'(j_reg);
            q_reg  <= '0;
        end
        else if (cmd.byte_next)
        begin
            q_reg <= q_reg + PS_W'(1);
        end
        if (cmd.pix_chk)
        begin
            sb_reg <= sb_c;
            db_reg <= db_c;
            ok_reg <= ok_c;
        end
    end

    assign host_idx = BADDR_W'(addr_reg);
    assign haddr_ok = host_idx < STORE_LIM;
    assign sq_addr  = sb_reg + BADDR_W'(q_reg);
    assign dq_addr  = db_reg + BADDR_W'(q_reg);

    // merge one sub-byte pixel into the destination byte
    always_comb
    begin
        v4     = sp_reg[0] ? srd_reg[3:0] : srd_reg[7:4];
        v2     = 2'(srd_reg >> {~sp_reg[1:0], 1'b0});
        dsh    = {~dp_reg[1:0], 1'b0};
        merged = drd_reg;
        case (ps_reg)
            PIX_NIBBLE:
            begin
                merged = dp_reg[0] ? {drd_reg[7:4], v4} : {v4, drd_reg[3:0]};
            end
            PIX_BIT:
            begin
                merged[~dp_reg[2:0]] = srd_reg[~sp_reg[2:0]];
            end
            PIX_DIBIT:
            begin
                merged = (drd_reg & ~(8'h03 << dsh)) | ({6'b0, v2} << dsh);
            end
            default:
            begin
                merged = srd_reg;
            end
        endcase
    end

    always_comb
    begin
        src_we    = cmd.host_wr && (kind_reg == KIND_WR_SRC) && haddr_ok;
        dst_we    = (cmd.host_wr && (kind_reg == KIND_WR_DST) && haddr_ok) || cmd.cp_wr;
        src_re    = cmd.host_rd || cmd.cp_rd;
        dst_re    = cmd.host_rd || cmd.cp_rd;
        src_addr  = cmd.host_rd ? host_idx : sq_addr;
        if (cmd.host_rd || cmd.host_wr)
        begin
            dst_addr = host_idx;
        end
        else if (cmd.cp_wr && !sub)
        begin
            dst_addr = dq_addr;
        end
        else
        begin
            dst_addr = db_reg;
        end
        if (cmd.host_wr)
        begin
            dst_wdata = data_reg;
        end
        else
        begin
            dst_wdata = sub ? merged : srd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[host_idx[AW-1:0]] <= data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_re)
        begin
            srd_reg <= src_mem[src_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dst_we)
        begin
            dst_mem[dst_addr[AW-1:0]] <= dst_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dst_re)
        begin
            drd_reg <= dst_mem[dst_addr[AW-1:0]];
        end
    end

    always_comb
    begin
        stat.kind      = kind_reg;
        stat.empty     = w_reg[DIM_W] || (w_reg == '0) || h_reg[DIM_W] || (h_reg == '0);
        stat.pix_ok    = ok_reg;
        stat.first_col = (j_reg == '0);
        stat.last_col  = (({1'b0, j_reg} + (DIM_W+1)'(1)) == w_reg);
        stat.last_row  = (({1'b0, i_reg} + (DIM_W+1)'(1)) == h_reg);
        stat.last_byte = sub || (({1'b0, q_reg} + (PS_W+1)'(1)) == {1'b0, ps_reg});
    end

    assign result_valid = valid_reg;
    assign read_data    = rdata_reg;
    assign copy_done    = done_reg;
    assign out_of_range = oor_out_reg;

endmodule
